[rtl/ajb_pkg.sv]
// Package: widths, register indexes, playout modes and payload types for the jitter buffer.
`timescale 1ns / 1ps
package ajb_pkg;

   localparam int STORE_FRAMES = 8192;
   localparam int SAMPLE_BITS  = 16;
   localparam int PTR_BITS     = $clog2(STORE_FRAMES);
   localparam int FILL_BITS    = PTR_BITS + 1;
   localparam int MAXF_BITS    = 13;
   localparam int BLOCK_BITS   = 11;
   localparam int COUNT_BITS   = 32;
   localparam int FRAME_BITS   = 2 * SAMPLE_BITS;

   // configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = (FILL_BITS > MAXF_BITS) ? FILL_BITS : MAXF_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_FILL = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_FILL    = 1'b1;

   localparam logic [FILL_BITS-1:0] TARGET_FILL_RESET = FILL_BITS'(1200);
   localparam logic [MAXF_BITS-1:0] MAX_FILL_RESET    = MAXF_BITS'(5760);

   // opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // playout block modes
   localparam logic [1:0] MODE_SILENCE = 2'd0;
   localparam logic [1:0] MODE_POP     = 2'd1;
   localparam logic [1:0] MODE_DRAIN   = 2'd2;

   typedef struct packed {
      logic                          opcode;
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic                          packet_last;
      logic                          block_start;
      logic [BLOCK_BITS-1:0]         block_frames;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic [FILL_BITS-1:0]          fill_level;
      logic [COUNT_BITS-1:0]         underrun_count;
      logic [COUNT_BITS-1:0]         overflow_count;
   } rsp_type;

endpackage

[rtl/audio_jitter_buffer.sv]
// Pipeline: two register stages; an accepted transaction passes stage 1 and then the result
//   register that drives the rsp port.
// Throughput: one transaction per cycle unless rsp_stall backs up; the frame store has one
//   write and one read port, the read data is registered and joins the result in stage 2.
// Reset (synchronous): pointers, fill, counters and block mode clear, prefill sets,
//   target_fill/max_fill take 1200/5760; frame store contents stay undefined, no sweep.
// Top level: frame FIFO with prefill, packet-end fill ceiling and underrun handling.
`timescale 1ns / 1ps
module audio_jitter_buffer
   import ajb_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   logic [FILL_BITS-1:0]  target_fill_ff;
   logic [MAXF_BITS-1:0]  max_fill_ff;

   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FILL_BITS-1:0]  count_ff, count_in;
   logic                  prefill_ff, prefill_in;
   logic [1:0]            mode_ff, mode_in;
   logic [COUNT_BITS-1:0] underruns_ff, underruns_in;
   logic [COUNT_BITS-1:0] overflows_ff, overflows_in;

   logic [FRAME_BITS-1:0] frame_store [STORE_FRAMES];
   logic [FRAME_BITS-1:0] rd_data_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_pop_ff, s1_pop_in;
   logic [FILL_BITS-1:0]  s1_fill_ff;
   logic [COUNT_BITS-1:0] s1_ur_ff;
   logic [COUNT_BITS-1:0] s1_ov_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  s1_adv;
   logic                  req_take;
   logic                  is_push;
   logic                  store_full;
   logic [PTR_BITS-1:0]   push_rp;
   logic [FILL_BITS-1:0]  push_cnt;
   logic [FILL_BITS-1:0]  max_ext;
   logic [FILL_BITS-1:0]  drop;
   logic [1:0]            pull_mode;
   logic                  pull_prefill;
   logic                  pull_ur;
   logic                  pull_pop;

   // result register frees when empty or being taken; stage 1 moves into it then
   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign is_push   = (req_data.opcode == OP_PUSH);

   // push path: a full store sheds its oldest frame first
   assign store_full = (count_ff == FILL_BITS'(STORE_FRAMES));
   assign push_rp    = store_full ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
   assign push_cnt   = store_full ? count_ff : count_ff + FILL_BITS'(1);
   assign max_ext    = FILL_BITS'(max_fill_ff);
   assign drop       = push_cnt - max_ext;

   // pull path: block decision at block start
   always_comb begin
      pull_mode    = mode_ff;
      pull_prefill = prefill_ff;
      pull_ur      = 1'b0;
      if (req_data.block_start) begin
         if (prefill_ff && (count_ff < target_fill_ff)) begin
            pull_mode = MODE_SILENCE;
         end else if (32'(count_ff) >= 32'(req_data.block_frames)) begin
            pull_mode    = MODE_POP;
            pull_prefill = 1'b0;
         end else begin
            pull_mode    = MODE_DRAIN;
            pull_prefill = 1'b1;
            pull_ur      = 1'b1;
         end
      end
      pull_pop = (pull_mode != MODE_SILENCE) && (count_ff != '0);
   end

   always_comb begin
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      prefill_in   = prefill_ff;
      mode_in      = mode_ff;
      underruns_in = underruns_ff;
      overflows_in = overflows_ff;
      s1_pop_in    = 1'b0;
      if (req_take) begin
         if (is_push) begin
            wr_ptr_in = wr_ptr_ff + PTR_BITS'(1);
            rd_ptr_in = push_rp;
            count_in  = push_cnt;
            if (req_data.packet_last && (push_cnt > max_ext)) begin
               rd_ptr_in    = push_rp + PTR_BITS'(drop);
               count_in     = max_ext;
               overflows_in = overflows_ff + COUNT_BITS'(1);
            end
         end else begin
            mode_in    = pull_mode;
            prefill_in = pull_prefill;
            s1_pop_in  = pull_pop;
            if (pull_ur) begin
               underruns_in = underruns_ff + COUNT_BITS'(1);
            end
            if (pull_pop) begin
               rd_ptr_in = rd_ptr_ff + PTR_BITS'(1);
               count_in  = count_ff - FILL_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      priority if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_adv) begin
         rsp_valid_in               = s1_valid_ff;
         rsp_data_in.left_out       = s1_pop_ff ? rd_data_ff[FRAME_BITS-1:SAMPLE_BITS] : '0;
         rsp_data_in.right_out      = s1_pop_ff ? rd_data_ff[SAMPLE_BITS-1:0] : '0;
         rsp_data_in.fill_level     = s1_fill_ff;
         rsp_data_in.underrun_count = s1_ur_ff;
         rsp_data_in.overflow_count = s1_ov_ff;
      end
   end

   // frame store: write at the tail on push, read the head on every accepted transaction
   always_ff @(posedge clock) begin
      if (req_take && is_push) begin
         frame_store[wr_ptr_ff] <= {req_data.left_in, req_data.right_in};
      end
      if (req_take) begin
         rd_data_ff <= frame_store[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_fill_ff <= TARGET_FILL_RESET;
         max_fill_ff    <= MAX_FILL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET_FILL: target_fill_ff <= FILL_BITS'(csr_wr_data);
            CSR_MAX_FILL:    max_fill_ff    <= MAXF_BITS'(csr_wr_data);
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         prefill_ff   <= 1'b1;
         mode_ff      <= MODE_SILENCE;
         underruns_ff <= '0;
         overflows_ff <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         prefill_ff   <= prefill_in;
         mode_ff      <= mode_in;
         underruns_ff <= underruns_in;
         overflows_ff <= overflows_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pop_ff  <= s1_pop_in;
         s1_fill_ff <= count_in;
         s1_ur_ff   <= underruns_in;
         s1_ov_ff   <= overflows_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/ajb_checker.sv]
// Checker: port-level properties of the jitter buffer, bound to the top level.
`timescale 1ns / 1ps
module ajb_checker
   import ajb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic                  have_prev_ff;
   logic [COUNT_BITS-1:0] prev_ur_ff;
   logic [COUNT_BITS-1:0] prev_ov_ff;
   logic                  rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (rsp_take) begin
         have_prev_ff <= 1'b1;
      end
      if (rsp_take) begin
         prev_ur_ff <= rsp_data.underrun_count;
         prev_ov_ff <= rsp_data.overflow_count;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // each transaction advances a counter by at most one
   a_ur_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && have_prev_ff |->
         rsp_data.underrun_count == prev_ur_ff ||
         rsp_data.underrun_count == prev_ur_ff + COUNT_BITS'(1))
      else $error("underrun count jumped");

   a_ov_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && have_prev_ff |->
         rsp_data.overflow_count == prev_ov_ff ||
         rsp_data.overflow_count == prev_ov_ff + COUNT_BITS'(1))
      else $error("overflow count jumped");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.fill_level <= FILL_BITS'(STORE_FRAMES))
      else $error("fill above store size");

endmodule

bind audio_jitter_buffer ajb_checker u_ajb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/tb_top.sv]
// Testbench for audio_jitter_buffer: directed playout cases plus random packet/block traffic.
`timescale 1ns / 1ps
module tb_top;
   import ajb_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int LATENCY     = 2;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   audio_jitter_buffer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the buffer
   logic [SAMPLE_BITS-1:0] pcm_left  [STORE_FRAMES];
   logic [SAMPLE_BITS-1:0] pcm_right [STORE_FRAMES];
   logic [PTR_BITS-1:0]    rd_ptr = '0;
   logic [PTR_BITS-1:0]    wr_ptr = '0;
   int                     held = 0;
   logic                   prefill_on = 1'b1;
   logic [1:0]             play_mode = MODE_SILENCE;
   logic [COUNT_BITS-1:0]  underruns_seen = '0;
   logic [COUNT_BITS-1:0]  overflows_seen = '0;
   int                     cfg_target = int'(TARGET_FILL_RESET);
   int                     cfg_max_fill = int'(MAX_FILL_RESET);

   rsp_type expected_playout[$];
   rsp_type playout_head;
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 18;
   int      recv_idle_pct = 46;
   int      stall_hold = 0;

   function automatic rsp_type predict_playout(input req_type item);
      rsp_type res;
      int      drop;
      res = '0;
      if (item.opcode == OP_PUSH) begin
         if (held >= STORE_FRAMES) begin
            // full store: oldest frame makes room, no overflow count
            rd_ptr++;
            held--;
         end
         pcm_left[wr_ptr]  = item.left_in;
         pcm_right[wr_ptr] = item.right_in;
         wr_ptr++;
         held++;
         if (item.packet_last && held > cfg_max_fill) begin
            drop = held - cfg_max_fill;
            rd_ptr += PTR_BITS'(drop);
            held = cfg_max_fill;
            overflows_seen++;
         end
      end else begin
         if (item.block_start) begin
            if (prefill_on && held < cfg_target) begin
               play_mode = MODE_SILENCE;
            end else begin
               prefill_on = 1'b0;
               if (held >= item.block_frames) begin
                  play_mode = MODE_POP;
               end else begin
                  play_mode = MODE_DRAIN;
                  underruns_seen++;
                  prefill_on = 1'b1;
               end
            end
         end
         if (play_mode != MODE_SILENCE && held > 0) begin
            res.left_out  = pcm_left[rd_ptr];
            res.right_out = pcm_right[rd_ptr];
            rd_ptr++;
            held--;
         end
      end
      res.fill_level     = FILL_BITS'(held);
      res.underrun_count = underruns_seen;
      res.overflow_count = overflows_seen;
      return res;
   endfunction

   function automatic req_type push_item(input logic [15:0] l, input logic [15:0] r,
                                         input logic last);
      req_type item;
      item             = '0;
      item.opcode      = OP_PUSH;
      item.left_in     = l;
      item.right_in    = r;
      item.packet_last = last;
      return item;
   endfunction

   function automatic req_type pull_item(input logic start, input int len);
      req_type item;
      item              = '0;
      item.opcode       = OP_PULL;
      item.block_start  = start;
      item.block_frames = BLOCK_BITS'(len);
      return item;
   endfunction

   // one transaction on the request side; prediction happens at acceptance
   task automatic send_frame(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_playout = {expected_playout, predict_playout(item)};
   endtask

   task automatic wait_idle;
      req_valid <= 1'b0;
      while (expected_playout.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input int target, input int ceiling);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_TARGET_FILL;
      csr_wr_data <= CSR_DATA_BITS'(target);
      @(posedge clock);
      csr_index   <= CSR_MAX_FILL;
      csr_wr_data <= CSR_DATA_BITS'(ceiling);
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      cfg_target   = target;
      cfg_max_fill = ceiling;
   endtask

   // reset register values: prefill keeps every block silent
   task automatic test_reset_defaults;
      send_frame(pull_item(1'b0, 0));
      send_frame(pull_item(1'b1, 1));
      send_frame(push_item(16'h7fff, 16'h8000, 1'b1));
      send_frame(push_item(16'hffff, 16'h0001, 1'b0));
      wait_idle();
   endtask

   task automatic test_playout_modes;
      configure(4, 6);
      send_frame(push_item(16'h8000, 16'h7fff, 1'b0));
      send_frame(push_item(16'h1234, 16'hedcb, 1'b0));
      send_frame(push_item(16'h0000, 16'hffff, 1'b1));
      send_frame(pull_item(1'b1, 3));
      send_frame(pull_item(1'b0, 0));
      send_frame(pull_item(1'b0, 0));
      send_frame(pull_item(1'b0, 0));
      // short of frames: underrun, leftovers then zeros
      send_frame(pull_item(1'b1, 1024));
      send_frame(pull_item(1'b0, 0));
      send_frame(pull_item(1'b0, 0));
      send_frame(push_item(16'h5a5a, 16'ha5a5, 1'b1));
      send_frame(pull_item(1'b0, 0));
      wait_idle();
      configure(0, 7168);
      // zero-length block pops, empty store plays zeros
      send_frame(pull_item(1'b1, 0));
      send_frame(pull_item(1'b1, 2047));
      wait_idle();
   endtask

   task automatic test_packet_overflow;
      int i;
      configure(6, 6);
      for (i = 0; i < 8; i++) begin
         send_frame(push_item(16'(i * 16'h1111), 16'(~(i * 16'h1111)), i == 7));
      end
      send_frame(pull_item(1'b1, 2));
      send_frame(pull_item(1'b0, 0));
      wait_idle();
   endtask

   task automatic test_full_store;
      int      i;
      req_type item;
      configure(8192, 7168);
      for (i = 0; i < STORE_FRAMES + 8; i++) begin
         item              = push_item(16'($urandom), 16'($urandom), 1'b0);
         item.block_start  = 1'($urandom);
         item.block_frames = BLOCK_BITS'($urandom);
         send_frame(item);
      end
      send_frame(pull_item(1'b1, 4));
      for (i = 0; i < 3; i++) send_frame(pull_item(1'b0, 0));
      wait_idle();
      // zero ceiling: packet end throws away everything held
      configure(8192, 0);
      send_frame(push_item(16'h7fff, 16'h7fff, 1'b1));
      send_frame(pull_item(1'b1, 1));
      wait_idle();
   endtask

   task automatic test_backpressure;
      int i;
      configure(16, 64);
      stall_hold = 80;
      for (i = 0; i < 40; i++) begin
         send_frame(push_item(16'($urandom), 16'($urandom), (i % 5) == 4));
      end
      for (i = 0; i < 20; i++) send_frame(pull_item(i % 10 == 0, 10));
      wait_idle();
   endtask

   task automatic test_random_traffic(input int phase_items);
      int          targets [6];
      int          ceilings[6];
      int          phase, sent, kind, n, len, pulls, i;
      logic [63:0] raw;
      req_type     item;
      targets  = '{0, 24, 8192, 40, 8, 16};
      ceilings = '{7168, 64, 1, 120, 20, 48};
      for (phase = 0; phase < 6; phase++) begin
         if (phase == 2) begin
            send_idle_pct = 46;
            recv_idle_pct = 18;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         configure(targets[phase], ceilings[phase]);
         sent = 0;
         while (sent < phase_items) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
               // packet; now and then the last marker is missing
               n = $urandom_range(1, 12);
               for (i = 0; i < n; i++) begin
                  item = push_item(16'($urandom), 16'($urandom),
                                   i == n - 1 && $urandom_range(19) != 0);
                  item.block_start  = 1'($urandom);
                  item.block_frames = BLOCK_BITS'($urandom);
                  send_frame(item);
               end
               sent += n;
            end else if (kind < 92) begin
               if ($urandom_range(19) == 0) begin
                  len   = $urandom_range(0, 2047);
                  pulls = $urandom_range(1, 8);
               end else begin
                  len   = $urandom_range(1, 16);
                  pulls = len + (($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0);
               end
               for (i = 0; i < pulls; i++) begin
                  item             = pull_item(i == 0, (i == 0) ? len : $urandom);
                  item.left_in     = SAMPLE_BITS'($urandom);
                  item.right_in    = SAMPLE_BITS'($urandom);
                  item.packet_last = 1'($urandom);
                  send_frame(item);
               end
               sent += pulls;
            end else begin
               raw  = {$urandom, $urandom};
               item = raw[$bits(req_type)-1:0];
               send_frame(item);
               sent++;
            end
         end
         wait_idle();
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_playout.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transaction: %p", rsp_data);
         end else begin
            playout_head = expected_playout.pop_front();
            if (rsp_data.left_out !== playout_head.left_out ||
                rsp_data.right_out !== playout_head.right_out ||
                rsp_data.fill_level !== playout_head.fill_level ||
                rsp_data.underrun_count !== playout_head.underrun_count ||
                rsp_data.overflow_count !== playout_head.overflow_count) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected L=%0d R=%0d fill=%0d ur=%0d of=%0d",
                           playout_head.left_out, playout_head.right_out,
                           playout_head.fill_level, playout_head.underrun_count,
                           playout_head.overflow_count);
                  $display("          actual   L=%0d R=%0d fill=%0d ur=%0d of=%0d",
                           rsp_data.left_out, rsp_data.right_out, rsp_data.fill_level,
                           rsp_data.underrun_count, rsp_data.overflow_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_playout_modes();
      test_packet_overflow();
      test_full_store();
      test_backpressure();
      test_random_traffic(325);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
